/* src/ecd_pkg.sv */
// shared types, constants and helpers for the epoch to civil date converter
package ecd_pkg;

	localparam int EPOCH_W = 32;
	localparam int YEAR_W  = 12;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int DAYS_W  = 16;
	localparam int DOE_W   = 18;
	localparam int YOE_W   = 9;
	localparam int DOY_W   = 9;
	localparam int MP_W    = 4;

	localparam int SECS_PER_MIN  = 60;
	localparam int MINS_PER_HOUR = 60;
	localparam int HOURS_PER_DAY = 24;

	// reciprocals: floor(n * RECIP >> SHIFT) is exact over the operand range used
	localparam logic [31:0] RECIP_15    = 32'h8888_8889;
	localparam int          SHIFT_15    = 35;
	localparam logic [17:0] RECIP_3     = 18'd174763;
	localparam int          SHIFT_3     = 19;
	localparam logic [15:0] RECIP_365_A = 16'd45965;
	localparam int          SHIFT_365_A = 24;
	localparam logic [17:0] RECIP_365_B = 18'd183860;
	localparam int          SHIFT_365_B = 26;
	localparam logic [10:0] RECIP_153   = 11'd1714;
	localparam int          SHIFT_153   = 18;

	// day counts relative to the era layout starting 0000-03-01
	localparam int DAYS_ERA5_START = 11017;   // first epoch day that falls in era 5
	localparam int DOE_ERA4_OFFSET = 135080;  // day of era of 1970-01-01
	localparam int DAYS_PER_CENTURY = 36524;
	localparam int DOE_LAST        = 146096;
	localparam int DAYS_PER_YEAR   = 365;
	localparam int YEAR_ERA4       = 1600;
	localparam int YEAR_ERA5       = 2000;

	localparam logic [MP_W-1:0]    MP_JANUARY = 4'd10;
	localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;

	typedef struct packed {
		logic [HOUR_W-1:0] hours;
		logic [MIN_W-1:0]  minutes;
		logic [SEC_W-1:0]  seconds;
	} tod_t;

	typedef struct packed {
		logic [DAYS_W-1:0] days;
		tod_t              tod;
	} front_item_t;

	// first day of year of each march-based month: floor((153 * mp + 2) / 5)
	function automatic logic [DOY_W-1:0] month_offset(input logic [MP_W-1:0] mp);
		logic [DOY_W-1:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

/* src/ecd_if.sv */
// valid/ready channel interfaces for epoch items and civil date items
interface ecd_in_if;
	logic                        valid;
	logic                        ready;
	logic [ecd_pkg::EPOCH_W-1:0] epoch_seconds;

	modport source (output valid, output epoch_seconds, input ready);
	modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface ecd_out_if;
	logic                        valid;
	logic                        ready;
	logic [ecd_pkg::YEAR_W-1:0]  year_number;
	logic [ecd_pkg::MONTH_W-1:0] month_number;
	logic [ecd_pkg::DAY_W-1:0]   day_of_month;
	logic [ecd_pkg::HOUR_W-1:0]  hours;
	logic [ecd_pkg::MIN_W-1:0]   minutes;
	logic [ecd_pkg::SEC_W-1:0]   seconds;

	modport source (output valid, output year_number, output month_number,
		output day_of_month, output hours, output minutes, output seconds, input ready);
	modport sink (input valid, input year_number, input month_number,
		input day_of_month, input hours, input minutes, input seconds, output ready);
endinterface

/* src/ecd_front.sv */
// front pipeline: splits epoch seconds into day count and time of day
module ecd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	ecd_in_if.sink               in_ch,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ecd_pkg::front_item_t out_item
);
	localparam int Stages = 4;

	logic [Stages-1:0] vld_q;
	logic [Stages-1:0] vld_in;
	logic [Stages:0]   adv;
	logic [Stages-1:0] ld;

	always_comb begin
		adv[Stages] = out_ready;
		for (int i = Stages - 1; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	assign vld_in = {vld_q[Stages-2:0], in_ch.valid};
	assign ld = adv[Stages-1:0] & vld_in;
	assign in_ch.ready = adv[0];
	assign out_valid = vld_q[Stages-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < Stages; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_in[i];
				end
			end
		end
	end

	// stage 1: seconds / 60
	logic [31:0] x_s1;
	logic [26:0] q1_s1;
	logic [61:0] prod1;
	assign prod1 = 62'(in_ch.epoch_seconds[31:2]) * 62'(ecd_pkg::RECIP_15);

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			x_s1  <= in_ch.epoch_seconds;
			q1_s1 <= prod1[ecd_pkg::SHIFT_15 +: 27];
		end
	end

	// stage 2: second of minute, minutes / 60
	logic [5:0]  sec_s2;
	logic [26:0] q1_s2;
	logic [20:0] q2_s2;
	logic [56:0] prod2;
	logic [5:0]  sec_d;
	assign prod2 = 57'(q1_s1[26:2]) * 57'(ecd_pkg::RECIP_15);
	assign sec_d = x_s1[5:0] - 6'(q1_s1 * 27'(ecd_pkg::SECS_PER_MIN));

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			sec_s2 <= sec_d;
			q1_s2  <= q1_s1;
			q2_s2  <= prod2[ecd_pkg::SHIFT_15 +: 21];
		end
	end

	// stage 3: minute of hour, hours / 24
	logic [5:0]  sec_s3;
	logic [5:0]  min_s3;
	logic [20:0] q2_s3;
	logic [15:0] days_s3;
	logic [35:0] prod3;
	logic [5:0]  min_d;
	assign prod3 = 36'(q2_s2[20:3]) * 36'(ecd_pkg::RECIP_3);
	assign min_d = q1_s2[5:0] - 6'(q2_s2 * 21'(ecd_pkg::MINS_PER_HOUR));

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			sec_s3  <= sec_s2;
			min_s3  <= min_d;
			q2_s3   <= q2_s2;
			days_s3 <= prod3[ecd_pkg::SHIFT_3 +: 16];
		end
	end

	// stage 4: hour of day
	ecd_pkg::front_item_t item_s4;
	logic [4:0] hr_d;
	assign hr_d = q2_s3[4:0] - 5'(days_s3 * 16'(ecd_pkg::HOURS_PER_DAY));

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			item_s4.days        <= days_s3;
			item_s4.tod.hours   <= hr_d;
			item_s4.tod.minutes <= min_s3;
			item_s4.tod.seconds <= sec_s3;
		end
	end

	assign out_item = item_s4;

endmodule

/* src/ecd_fifo.sv */
// small register queue between the front and back pipelines
module ecd_fifo #(
	parameter int Depth = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  ecd_pkg::front_item_t push_item,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output ecd_pkg::front_item_t pop_item
);
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	ecd_pkg::front_item_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = cnt_q != CntW'(Depth);
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* src/ecd_back.sv */
// back pipeline: civil date from day count, carries time of day alongside
module ecd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ecd_pkg::front_item_t in_item,
	ecd_out_if.source            out_ch
);
	localparam int Stages = 7;

	logic [Stages-1:0] vld_q;
	logic [Stages-1:0] vld_in;
	logic [Stages:0]   adv;
	logic [Stages-1:0] ld;

	always_comb begin
		adv[Stages] = out_ch.ready;
		for (int i = Stages - 1; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	assign vld_in = {vld_q[Stages-2:0], in_valid};
	assign ld = adv[Stages-1:0] & vld_in;
	assign in_ready = adv[0];
	assign out_ch.valid = vld_q[Stages-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < Stages; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_in[i];
				end
			end
		end
	end

	// stage 1: era (4 or 5 over the whole input range) and day of era
	logic [17:0]   doe_s1;
	logic          era5_s1;
	ecd_pkg::tod_t tod_s1;
	logic          era5_d;
	logic [17:0]   doe_d;
	assign era5_d = in_item.days >= 16'(ecd_pkg::DAYS_ERA5_START);
	assign doe_d  = era5_d ? 18'(in_item.days - 16'(ecd_pkg::DAYS_ERA5_START))
		: 18'(in_item.days) + 18'(ecd_pkg::DOE_ERA4_OFFSET);

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			doe_s1  <= doe_d;
			era5_s1 <= era5_d;
			tod_s1  <= in_item.tod;
		end
	end

	// stage 2: leap corrections doe/1460, doe/36524, doe/146096
	logic [17:0]   doe_s2;
	logic          era5_s2;
	ecd_pkg::tod_t tod_s2;
	logic [6:0]    c4y_s2;
	logic [2:0]    c100y_s2;
	logic          clast_s2;
	logic [31:0]   prod_a;
	assign prod_a = 32'(doe_s1[17:2]) * 32'(ecd_pkg::RECIP_365_A);

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			doe_s2   <= doe_s1;
			era5_s2  <= era5_s1;
			tod_s2   <= tod_s1;
			c4y_s2   <= prod_a[ecd_pkg::SHIFT_365_A +: 7];
			c100y_s2 <= 3'(doe_s1 >= 18'(ecd_pkg::DAYS_PER_CENTURY))
				+ 3'(doe_s1 >= 18'(2 * ecd_pkg::DAYS_PER_CENTURY))
				+ 3'(doe_s1 >= 18'(3 * ecd_pkg::DAYS_PER_CENTURY))
				+ 3'(doe_s1 >= 18'(4 * ecd_pkg::DAYS_PER_CENTURY));
			clast_s2 <= doe_s1 >= 18'(ecd_pkg::DOE_LAST);
		end
	end

	// stage 3: day of era with leap days removed
	logic [17:0]   doe_s3;
	logic          era5_s3;
	ecd_pkg::tod_t tod_s3;
	logic [17:0]   adj_s3;

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			doe_s3  <= doe_s2;
			era5_s3 <= era5_s2;
			tod_s3  <= tod_s2;
			adj_s3  <= doe_s2 - 18'(c4y_s2) + 18'(c100y_s2) - 18'(clast_s2);
		end
	end

	// stage 4: year of era = adj / 365
	logic [17:0]   doe_s4;
	logic          era5_s4;
	ecd_pkg::tod_t tod_s4;
	logic [8:0]    yoe_s4;
	logic [35:0]   prod_b;
	assign prod_b = 36'(adj_s3) * 36'(ecd_pkg::RECIP_365_B);

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			doe_s4  <= doe_s3;
			era5_s4 <= era5_s3;
			tod_s4  <= tod_s3;
			yoe_s4  <= prod_b[ecd_pkg::SHIFT_365_B +: 9];
		end
	end

	// stage 5: day of march-based year and march-based year number
	logic [8:0]    doy_s5;
	logic [11:0]   yr_s5;
	ecd_pkg::tod_t tod_s5;
	logic [1:0]    cent_d;
	logic [17:0]   ystart_d;
	assign cent_d = 2'(yoe_s4 >= 9'd100) + 2'(yoe_s4 >= 9'd200) + 2'(yoe_s4 >= 9'd300);
	assign ystart_d = 18'(yoe_s4) * 18'(ecd_pkg::DAYS_PER_YEAR) + 18'(yoe_s4[8:2])
		- 18'(cent_d);

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			doy_s5 <= 9'(doe_s4 - ystart_d);
			yr_s5  <= 12'(yoe_s4) + (era5_s4 ? 12'(ecd_pkg::YEAR_ERA5)
				: 12'(ecd_pkg::YEAR_ERA4));
			tod_s5 <= tod_s4;
		end
	end

	// stage 6: march-based month = (5 * doy + 2) / 153
	logic [8:0]    doy_s6;
	logic [11:0]   yr_s6;
	ecd_pkg::tod_t tod_s6;
	logic [3:0]    mp_s6;
	logic [10:0]   mnum_d;
	logic [21:0]   prod_m;
	assign mnum_d = 11'(doy_s5) * 11'd5 + 11'd2;
	assign prod_m = 22'(mnum_d) * 22'(ecd_pkg::RECIP_153);

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			doy_s6 <= doy_s5;
			yr_s6  <= yr_s5;
			tod_s6 <= tod_s5;
			mp_s6  <= prod_m[ecd_pkg::SHIFT_153 +: 4];
		end
	end

	// stage 7: output register, calendar month and january/february year bump
	logic [11:0]   yr_s7;
	logic [3:0]    mon_s7;
	logic [4:0]    day_s7;
	ecd_pkg::tod_t tod_s7;
	logic [3:0]    mon_d;
	assign mon_d = (mp_s6 < ecd_pkg::MP_JANUARY) ? mp_s6 + 4'd3 : mp_s6 - 4'd9;

	always_ff @(posedge clk) begin
		if (ld[6]) begin
			yr_s7  <= yr_s6 + 12'(mon_d <= ecd_pkg::MONTH_FEB);
			mon_s7 <= mon_d;
			day_s7 <= 5'(doy_s6 - ecd_pkg::month_offset(mp_s6) + 9'd1);
			tod_s7 <= tod_s6;
		end
	end

	assign out_ch.year_number  = yr_s7;
	assign out_ch.month_number = mon_s7;
	assign out_ch.day_of_month = day_s7;
	assign out_ch.hours        = tod_s7.hours;
	assign out_ch.minutes      = tod_s7.minutes;
	assign out_ch.seconds      = tod_s7.seconds;

endmodule

/* src/epoch_to_civil_datetime.sv */
// top level: epoch seconds to proleptic gregorian date and utc time of day
// an accepted item passes through 4 front stages, 1 queue entry and 7 back stages
// throughput: one item per cycle while the result side holds ready high
// the queue absorbs output stalls so the front keeps accepting until it fills
// reset clears all stage valid bits and the queue pointers, no payload reset
module epoch_to_civil_datetime #(
	parameter int QUEUE_DEPTH = 4
) (
	input logic       clk,
	input logic       arst_n,
	ecd_in_if.sink    in_ch,
	ecd_out_if.source out_ch
);
	logic                 fr_valid;
	logic                 fr_ready;
	ecd_pkg::front_item_t fr_item;
	logic                 bk_valid;
	logic                 bk_ready;
	ecd_pkg::front_item_t bk_item;

	ecd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_item  (fr_item)
	);

	ecd_fifo #(
		.Depth (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_item  (fr_item),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_item   (bk_item)
	);

	ecd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bk_valid),
		.in_ready (bk_ready),
		.in_item  (bk_item),
		.out_ch   (out_ch)
	);

endmodule

/* tb/civil_date_checker.sv */
// checker: predicts civil date and time for every accepted epoch item and compares results
module civil_date_checker (
	input  logic clk,
	input  logic arst_n,
	ecd_in_if    in_mon,
	ecd_out_if   out_mon,
	output int   mismatch_count,
	output int   outstanding
);

	localparam int unsigned MARCH_ORIGIN_DAYS = 719468;
	localparam int unsigned ERA_DAYS          = 146097;
	localparam int unsigned ERA_YEARS         = 400;
	localparam int unsigned MAX_REPORTS       = 40;

	typedef struct packed {
		logic [ecd_pkg::YEAR_W-1:0]  year;
		logic [ecd_pkg::MONTH_W-1:0] month;
		logic [ecd_pkg::DAY_W-1:0]   day;
		logic [ecd_pkg::HOUR_W-1:0]  hours;
		logic [ecd_pkg::MIN_W-1:0]   minutes;
		logic [ecd_pkg::SEC_W-1:0]   seconds;
	} civil_dt_t;

	typedef struct {
		logic [ecd_pkg::EPOCH_W-1:0] epoch;
		civil_dt_t                   civil;
	} dated_item_t;

	dated_item_t expected_dates[$];

	initial begin
		mismatch_count = 0;
		outstanding    = 0;
	end

	// split off time of day, then march-based era / year / month arithmetic
	function automatic civil_dt_t civil_from_epoch(input logic [ecd_pkg::EPOCH_W-1:0] t);
		int unsigned rest, days, z, era, doe, yoe, doy, mp, mon, yr;
		civil_dt_t d;
		rest      = t;
		d.seconds = ecd_pkg::SEC_W'(rest % 60);
		rest      = rest / 60;
		d.minutes = ecd_pkg::MIN_W'(rest % 60);
		rest      = rest / 60;
		d.hours   = ecd_pkg::HOUR_W'(rest % 24);
		days      = rest / 24;
		z   = days + MARCH_ORIGIN_DAYS;
		era = z / ERA_DAYS;
		doe = z - era * ERA_DAYS;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		yr  = yoe + era * ERA_YEARS;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp  = (5 * doy + 2) / 153;
		d.day = ecd_pkg::DAY_W'(doy - (153 * mp + 2) / 5 + 1);
		mon = (mp < 10) ? mp + 3 : mp - 9;
		// january and february belong to the next civil year
		if (mon <= 2)
			yr = yr + 1;
		d.month = ecd_pkg::MONTH_W'(mon);
		d.year  = ecd_pkg::YEAR_W'(yr);
		return d;
	endfunction

	task automatic report_mismatch(input string what,
		input logic [ecd_pkg::EPOCH_W-1:0] epoch, input int got, input int want);
		if (mismatch_count < MAX_REPORTS)
			$display("[%0t] ERROR epoch %0d: %s got %0d want %0d", $time, epoch, what, got,
				want);
		mismatch_count++;
	endtask

	task automatic compare_result();
		dated_item_t exp_item;
		if (expected_dates.size() == 0) begin
			report_mismatch("unexpected result", '0, 0, 0);
			return;
		end
		exp_item = expected_dates.pop_front();
		if (out_mon.year_number !== exp_item.civil.year)
			report_mismatch("year", exp_item.epoch, out_mon.year_number, exp_item.civil.year);
		if (out_mon.month_number !== exp_item.civil.month)
			report_mismatch("month", exp_item.epoch, out_mon.month_number, exp_item.civil.month);
		if (out_mon.day_of_month !== exp_item.civil.day)
			report_mismatch("day", exp_item.epoch, out_mon.day_of_month, exp_item.civil.day);
		if (out_mon.hours !== exp_item.civil.hours)
			report_mismatch("hours", exp_item.epoch, out_mon.hours, exp_item.civil.hours);
		if (out_mon.minutes !== exp_item.civil.minutes)
			report_mismatch("minutes", exp_item.epoch, out_mon.minutes, exp_item.civil.minutes);
		if (out_mon.seconds !== exp_item.civil.seconds)
			report_mismatch("seconds", exp_item.epoch, out_mon.seconds, exp_item.civil.seconds);
	endtask

	always @(posedge clk) begin
		dated_item_t new_item;
		if (arst_n) begin
			if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1)
				compare_result();
			if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
				new_item.epoch = in_mon.epoch_seconds;
				new_item.civil = civil_from_epoch(in_mon.epoch_seconds);
				expected_dates.push_back(new_item);
			end
			outstanding <= expected_dates.size();
		end
	end

endmodule

/* tb/tb_epoch_to_civil_datetime.sv */
// testbench top: clock, reset, epoch stimulus, result-side stalls and the verdict
module tb_epoch_to_civil_datetime;

	localparam int RANDOM_ITEMS  = 700;
	localparam int HOLD_CYCLES   = 80;
	localparam int HOLD_AFTER    = 250;
	localparam int PAUSE_AT      = 400;
	localparam int STEADY_FROM   = 500;
	localparam int STEADY_TO     = 600;
	localparam int DRAIN_CYCLES  = 30;
	localparam int IDLE_LIMIT    = 2000;
	localparam int unsigned SECS_PER_DAY  = 86400;
	localparam int unsigned LAST_FULL_DAY = 49709;

	logic clk;
	logic arst_n;
	logic steady;
	int   mismatch_count;
	int   outstanding;
	int   epochs_sent;
	int   directed_sent;
	int   results_seen;
	int   idle_cycles;
	bit   long_hold_done;

	ecd_in_if  in_ch();
	ecd_out_if out_ch();

	epoch_to_civil_datetime dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	civil_date_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_mon         (in_ch),
		.out_mon        (out_ch),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic int unsigned pick_field(input int unsigned max_val);
		int unsigned r;
		r = $urandom_range(3);
		if (r == 0)
			return 0;
		if (r == 1)
			return max_val;
		return $urandom_range(max_val);
	endfunction

	// random epochs weighted toward day edges and the ends of the range
	function automatic logic [ecd_pkg::EPOCH_W-1:0] pick_epoch();
		int unsigned mode, day_idx, tod;
		mode    = $urandom_range(3);
		day_idx = $urandom_range(LAST_FULL_DAY);
		case (mode)
			0: begin
				return $urandom();
			end
			1: begin
				tod = $urandom_range(1) ? $urandom_range(5) : SECS_PER_DAY - 1 - $urandom_range(5);
				return day_idx * SECS_PER_DAY + tod;
			end
			2: begin
				tod = pick_field(23) * 3600 + pick_field(59) * 60 + pick_field(59);
				return day_idx * SECS_PER_DAY + tod;
			end
			default: begin
				if ($urandom_range(1))
					return 32'hFFFF_FFFF - $urandom_range(200000);
				return $urandom_range(200000);
			end
		endcase
	endfunction

	task automatic offer_epoch(input logic [ecd_pkg::EPOCH_W-1:0] value);
		int unsigned gap;
		in_ch.valid         <= 1'b1;
		in_ch.epoch_seconds <= value;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		epochs_sent++;
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			in_ch.valid         <= 1'b0;
			in_ch.epoch_seconds <= $urandom();
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_all_results();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// result side: random stalls, one long hold-off, no stalls during the steady stretch
	initial begin
		int unsigned stall_left;
		stall_left     = 0;
		results_seen   = 0;
		long_hold_done = 1'b0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
				results_seen++;
			if (!long_hold_done && results_seen >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else if (steady) begin
				out_ch.ready <= 1'b1;
			end else if (stall_left != 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// watchdog: too long without any item moving on either side
	always @(posedge clk) begin
		if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
			(out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: %0d items sent, %0d results pending", epochs_sent, outstanding);
			$display("epoch_to_civil_datetime: mismatch");
			$finish;
		end
	end

	initial begin
		logic [ecd_pkg::EPOCH_W-1:0] directed[$];
		directed = '{
			32'd0,             // epoch start, 1970-01-01 00:00:00
			32'hFFFF_FFFF,     // last representable second, 2106-02-07
			32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
			32'd5097599,       // 1970-02-28 end of day
			32'd68169600,      // 1972-02-29
			32'd946684799,     // 1999-12-31 23:59:59
			32'd946684800,     // 2000-01-01, still in era 4 of the march-based layout
			32'd951782400,     // 2000-02-29 century leap day
			32'd951868800,     // 2000-03-01
			32'd978220799,     // 2000-12-30 23:59:59, day 365
			32'd2147483647, 32'd2147483648,
			32'd4107542399,    // 2100-02-28 23:59:59, no leap day in 2100
			32'd4107542400,    // 2100-03-01
			32'h5555_5555, 32'hAAAA_AAAA
		};
		steady              = 1'b0;
		epochs_sent         = 0;
		idle_cycles         = 0;
		arst_n              <= 1'b0;
		in_ch.valid         <= 1'b0;
		in_ch.epoch_seconds <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			offer_epoch(directed[i]);
		directed_sent = epochs_sent;
		wait_all_results();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= STEADY_FROM && i < STEADY_TO);
			if (i == PAUSE_AT)
				wait_all_results();
			offer_epoch(pick_epoch());
		end
		steady = 1'b0;
		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d epoch items (%0d directed: range ends, day and leap-day edges)",
			epochs_sent, directed_sent);
		$display("checked %0d results under random stalls, one long output hold, one drain",
			results_seen);
		if (mismatch_count == 0)
			$display("epoch_to_civil_datetime: match");
		else
			$display("epoch_to_civil_datetime: mismatch");
		$finish;
	end

endmodule
